/* rtl/hts_pkg.sv */
// Shared types and constants for the heightmap terrain sampler.
// No dependencies; every other file refers to this package by scoped names.
package hts_pkg;

  localparam int GRID_DIM   = 256;
  localparam int GRID_BITS  = $clog2(GRID_DIM);
  localparam int BANK_AW    = 2 * (GRID_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INV_CELL  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_GRID_PTS  = 3'd4;

  localparam logic        OP_WRITE = 1'b0;
  localparam logic        OP_QUERY = 1'b1;

  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [8:0]  GP_MIN       = 9'd2;
  localparam logic [8:0]  GP_MAX       = 9'(GRID_DIM);
  localparam logic [23:0] INV_CELL_RST = 24'd65536;
  // Rounded divide by three: (s + THIRD_BIAS) * THIRD_MUL >> 19, minus THIRD_OFFSET
  localparam logic [17:0] THIRD_BIAS   = 18'd120001;
  localparam logic [17:0] THIRD_MUL    = 18'd174763;
  localparam logic [16:0] THIRD_OFFSET = 17'd40000;

  typedef struct packed {
    logic                    op;
    logic signed [31:0]      pos_x;
    logic signed [31:0]      pos_z;
    logic [7:0]              vertex_col;
    logic [7:0]              vertex_row;
    logic signed [31:0]      vertex_height;
    logic signed [15:0]      vertex_nx;
    logic signed [15:0]      vertex_ny;
    logic signed [15:0]      vertex_nz;
  } in_t;

  typedef struct packed {
    logic signed [31:0]      height;
    logic signed [15:0]      avg_nx;
    logic signed [15:0]      avg_ny;
    logic signed [15:0]      avg_nz;
    logic                    in_range;
  } out_t;

  typedef struct packed {
    logic signed [31:0]      height;
    logic signed [15:0]      nx;
    logic signed [15:0]      ny;
    logic signed [15:0]      nz;
  } entry_t;

  typedef struct packed {
    logic                    qv;
    logic                    inr;
    logic [15:0]             fx;
    logic [15:0]             fz;
    logic                    gx0;
    logic                    gz0;
  } qctl_t;

endpackage

/* rtl/hts_bank.sv */
// One parity bank of the vertex store: one write port, one registered read port.
// Depends on hts_pkg for entry type and depth.
module hts_bank (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [hts_pkg::BANK_AW-1:0]  waddr,
  input  hts_pkg::entry_t              wdata,
  input  logic [hts_pkg::BANK_AW-1:0]  raddr,
  output hts_pkg::entry_t              rdata
);

  hts_pkg::entry_t mem [hts_pkg::BANK_DEPTH];
  hts_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hts_addr.sv */
// Front of the pipeline: origin subtract, scale by inverse cell size, cell and
// fraction extraction, bank addressing and vertex writes. Depends on hts_pkg.
module hts_addr (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       in_acc,
  input  hts_pkg::in_t                               in_data,
  input  logic [31:0]                                origin_x,
  input  logic [31:0]                                origin_z,
  input  logic [23:0]                                inv_cell,
  input  logic [8:0]                                 grid_pts,
  output logic [hts_pkg::NUM_BANKS-1:0]              bank_we,
  output logic [hts_pkg::BANK_AW-1:0]                waddr,
  output hts_pkg::entry_t                            wdata,
  output logic [hts_pkg::NUM_BANKS-1:0][hts_pkg::BANK_AW-1:0] raddr,
  output hts_pkg::qctl_t                             qctl
);

  logic               v1_r, v2_r, qv_r;
  hts_pkg::in_t       item1_r, item2_r;
  logic signed [32:0] tx1_r, tz1_r;
  logic signed [57:0] px2_r, pz2_r;
  hts_pkg::qctl_t     qctl_r, qctl_nxt;
  logic [8:0]         gp_c;
  logic [8:0]         lim;
  logic [7:0]         gx, gz;
  logic               inr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      qv_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      qv_r <= qctl_nxt.qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1_r <= in_data;
      tx1_r   <= $signed({in_data.pos_x[31], in_data.pos_x}) -
                 $signed({origin_x[31], origin_x});
      tz1_r   <= $signed({in_data.pos_z[31], in_data.pos_z}) -
                 $signed({origin_z[31], origin_z});
      item2_r <= item1_r;
      px2_r   <= tx1_r * $signed({1'b0, inv_cell});
      pz2_r   <= tz1_r * $signed({1'b0, inv_cell});
      qctl_r  <= qctl_nxt;
    end
  end

  always_comb begin
    if (grid_pts < hts_pkg::GP_MIN) begin
      gp_c = hts_pkg::GP_MIN;
    end else if (grid_pts > hts_pkg::GP_MAX) begin
      gp_c = hts_pkg::GP_MAX;
    end else begin
      gp_c = grid_pts;
    end
    lim = gp_c - 9'd1;
    inr = !px2_r[57] && !pz2_r[57] &&
          (px2_r[56:32] < {16'd0, lim}) && (pz2_r[56:32] < {16'd0, lim});
    gx  = px2_r[39:32];
    gz  = pz2_r[39:32];
  end

  // Each of the four cell corners falls in a different parity bank.
  always_comb begin
    logic [7:0] c, r;
    for (int b = 0; b < hts_pkg::NUM_BANKS; b++) begin
      c = gx + {7'd0, gx[0] != b[1]};
      r = gz + {7'd0, gz[0] != b[0]};
      raddr[b] = {c[7:1], r[7:1]};
    end
  end

  always_comb begin
    logic [1:0] wb;
    wb = {item2_r.vertex_col[0], item2_r.vertex_row[0]};
    for (int b = 0; b < hts_pkg::NUM_BANKS; b++) begin
      bank_we[b] = v2_r && (item2_r.op == hts_pkg::OP_WRITE) && (wb == 2'(b));
    end
  end

  assign waddr = {item2_r.vertex_col[7:1], item2_r.vertex_row[7:1]};
  assign wdata = '{height: item2_r.vertex_height, nx: item2_r.vertex_nx,
                   ny: item2_r.vertex_ny, nz: item2_r.vertex_nz};

  always_comb begin
    qctl_nxt.qv  = v2_r && (item2_r.op == hts_pkg::OP_QUERY);
    qctl_nxt.inr = inr;
    qctl_nxt.fx  = px2_r[31:16];
    qctl_nxt.fz  = pz2_r[31:16];
    qctl_nxt.gx0 = gx[0];
    qctl_nxt.gz0 = gz[0];
  end

  // Take the valid flag from its reset register.
  always_comb begin
    qctl    = qctl_r;
    qctl.qv = qv_r;
  end

endmodule

/* rtl/hts_blend.sv */
// Back of the pipeline: triangle pick, barycentric weights, height blend with
// rounding and saturation, normal average, output register. Depends on hts_pkg.
module hts_blend (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  hts_pkg::qctl_t                         qctl,
  input  hts_pkg::entry_t [hts_pkg::NUM_BANKS-1:0] rdata,
  input  logic [31:0]                            origin_y,
  output logic                                   out_valid,
  output hts_pkg::out_t                          out_data
);

  logic                      lower;
  logic [16:0]               fsum, wa, wb, wc;
  hts_pkg::entry_t           ea, eb, ec;
  logic signed [49:0]        pa, pb, pc;
  logic signed [17:0]        ns [3];

  logic                      v4_r, v5_r, out_valid_r;
  logic                      inr4_r, inr5_r;
  logic signed [49:0]        pa_r, pb_r, pc_r;
  logic signed [17:0]        ns_r [3];
  logic signed [35:0]        hr_r;
  logic [16:0]               q_r [3];
  hts_pkg::out_t             out_r;

  logic signed [51:0]        acc;
  logic [17:0]               nt [3];
  logic [35:0]               np [3];
  logic signed [36:0]        hs;
  logic signed [31:0]        hsat;
  logic [16:0]               nq [3];

  always_comb begin
    fsum  = {1'b0, qctl.fx} + {1'b0, qctl.fz};
    lower = fsum <= hts_pkg::WEIGHT_ONE;
    ec    = rdata[{qctl.gx0, ~qctl.gz0}];
    if (lower) begin
      ea = rdata[{qctl.gx0, qctl.gz0}];
      eb = rdata[{~qctl.gx0, qctl.gz0}];
      wa = hts_pkg::WEIGHT_ONE - fsum;
      wb = {1'b0, qctl.fx};
      wc = {1'b0, qctl.fz};
    end else begin
      ea = rdata[{~qctl.gx0, qctl.gz0}];
      eb = rdata[{~qctl.gx0, ~qctl.gz0}];
      wa = hts_pkg::WEIGHT_ONE - {1'b0, qctl.fz};
      wb = fsum - hts_pkg::WEIGHT_ONE;
      wc = hts_pkg::WEIGHT_ONE - {1'b0, qctl.fx};
    end
    pa = ea.height * $signed({1'b0, wa});
    pb = eb.height * $signed({1'b0, wb});
    pc = ec.height * $signed({1'b0, wc});
    ns[0] = 18'(ea.nx) + 18'(eb.nx) + 18'(ec.nx);
    ns[1] = 18'(ea.ny) + 18'(eb.ny) + 18'(ec.ny);
    ns[2] = 18'(ea.nz) + 18'(eb.nz) + 18'(ec.nz);
  end

  always_comb begin
    acc = 52'(pa_r) + 52'(pb_r) + 52'(pc_r) + 52'sd32768;
    for (int k = 0; k < 3; k++) begin
      nt[k] = 18'(19'({ns_r[k][17], ns_r[k]}) + {1'b0, hts_pkg::THIRD_BIAS});
      np[k] = nt[k] * hts_pkg::THIRD_MUL;
    end
  end

  always_comb begin
    hs = {hr_r[35], hr_r} + {{5{origin_y[31]}}, origin_y};
    if (hs > 37'sd2147483647) begin
      hsat = 32'sh7FFFFFFF;
    end else if (hs < -37'sd2147483648) begin
      hsat = 32'sh80000000;
    end else begin
      hsat = hs[31:0];
    end
    for (int k = 0; k < 3; k++) begin
      nq[k] = q_r[k] - hts_pkg::THIRD_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v4_r        <= qctl.qv;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr4_r <= qctl.inr;
      pa_r   <= pa;
      pb_r   <= pb;
      pc_r   <= pc;
      inr5_r <= inr4_r;
      hr_r   <= acc[51:16];
      for (int k = 0; k < 3; k++) begin
        ns_r[k] <= ns[k];
        q_r[k]  <= np[k][35:19];
      end
      if (inr5_r) begin
        out_r <= '{height: hsat, avg_nx: nq[0][15:0], avg_ny: nq[1][15:0],
                   avg_nz: nq[2][15:0], in_range: 1'b1};
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/heightmap_terrain_sampler_unit.sv */
// Top level of the heightmap terrain sampler: configuration registers, the
// parity-banked vertex store and the pipeline. Depends on hts_pkg and submodules.
//
// Takes one transaction per cycle, writes and queries alike, and raises a query's
// result after the address, bank read and blend registers. The vertex store is
// split into four banks by column and row parity, so the three corners of a
// triangle are read together; writes land at the same pipeline stage as the
// reads, so a query always sees every write accepted before it. A stall on the
// output holds the whole pipeline. Configuration is taken every cycle.
module heightmap_terrain_sampler_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hts_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hts_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hts_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);

  logic [31:0] origin_x_r, origin_y_r, origin_z_r;
  logic [23:0] inv_cell_r;
  logic [8:0]  grid_pts_r;
  logic        en;

  logic [hts_pkg::NUM_BANKS-1:0]                        bank_we;
  logic [hts_pkg::BANK_AW-1:0]                          waddr;
  hts_pkg::entry_t                                      wdata;
  logic [hts_pkg::NUM_BANKS-1:0][hts_pkg::BANK_AW-1:0]  raddr;
  hts_pkg::entry_t [hts_pkg::NUM_BANKS-1:0]             rdata;
  hts_pkg::qctl_t                                       qctl;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      inv_cell_r <= hts_pkg::INV_CELL_RST;
      grid_pts_r <= hts_pkg::GP_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hts_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        hts_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        hts_pkg::CFG_ORIGIN_Z: origin_z_r <= cfg_data;
        hts_pkg::CFG_INV_CELL: inv_cell_r <= cfg_data[23:0];
        hts_pkg::CFG_GRID_PTS: grid_pts_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  hts_addr u_addr (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_acc   (in_valid && in_ready),
    .in_data  (in_data),
    .origin_x (origin_x_r),
    .origin_z (origin_z_r),
    .inv_cell (inv_cell_r),
    .grid_pts (grid_pts_r),
    .bank_we  (bank_we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .qctl     (qctl)
  );

  for (genvar b = 0; b < hts_pkg::NUM_BANKS; b++) begin : g_bank
    hts_bank u_bank (
      .clk   (clk),
      .en    (en),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  hts_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .qctl      (qctl),
    .rdata     (rdata),
    .origin_y  (origin_y_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/hts_checker.sv */
// Port-level checks for the terrain sampler, bound to the top level.
// Depends on hts_pkg for the payload types.
module hts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input hts_pkg::out_t              out_data,
  input logic                       cfg_ready
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // An off-grid result carries all zero fields.
  a_off_grid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_range |->
      out_data.height == 0 && out_data.avg_nx == 0 &&
      out_data.avg_ny == 0 && out_data.avg_nz == 0)
    else $error("off-grid result not zero");

  // Input backpressure only comes from a stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind heightmap_terrain_sampler_unit hts_checker u_hts_checker (.*);

/* bench/tb_heightmap_terrain_sampler_unit.sv */
// Self-checking bench for heightmap_terrain_sampler_unit: vertex writes and height
// queries over valid/ready channels, checked against a cycle-free scoreboard model.
// Depends on hts_pkg and the RTL of the sampler.
`timescale 1ns / 1ps

module tb_heightmap_terrain_sampler_unit;

  class terrain_scoreboard;
    logic [31:0] org_x, org_y, org_z;
    logic [23:0] inv_cell;
    logic [8:0]  grid_pts;
    logic [31:0] vtx_height [0:65535];
    logic [47:0] vtx_normal [0:65535];
    bit          vtx_written [0:65535];
    hts_pkg::out_t expected_q[$];
    int          errors;

    function new();
      org_x = '0; org_y = '0; org_z = '0;
      inv_cell = hts_pkg::INV_CELL_RST;
      grid_pts = hts_pkg::GP_MAX;
      errors = 0;
    endfunction

    function void write_reg(logic [hts_pkg::CFG_IW-1:0] idx, logic [31:0] data);
      case (idx)
        hts_pkg::CFG_ORIGIN_X: org_x = data;
        hts_pkg::CFG_ORIGIN_Y: org_y = data;
        hts_pkg::CFG_ORIGIN_Z: org_z = data;
        hts_pkg::CFG_INV_CELL: inv_cell = data[23:0];
        hts_pkg::CFG_GRID_PTS: grid_pts = data[8:0];
        default: ;
      endcase
    endfunction

    // Find the triangle a query lands on; inr low means off the grid.
    function void locate(hts_pkg::in_t d, output bit inr, output int ia, output int ib,
                         output int ic, output longint wa, output longint wb,
                         output longint wc);
      longint gp, px, pz, gx, gz, fx, fz;
      int i00;
      gp = (grid_pts < hts_pkg::GP_MIN) ? 2 :
           ((grid_pts > hts_pkg::GP_MAX) ? hts_pkg::GRID_DIM : grid_pts);
      px = (longint'(d.pos_x) - longint'($signed(org_x))) * longint'(inv_cell);
      pz = (longint'(d.pos_z) - longint'($signed(org_z))) * longint'(inv_cell);
      inr = 0; ia = 0; ib = 0; ic = 0; wa = 0; wb = 0; wc = 0;
      if (px < 0 || pz < 0) return;
      gx = px >>> 32;
      gz = pz >>> 32;
      if (gx >= gp - 1 || gz >= gp - 1) return;
      fx = (px >>> 16) & 64'hFFFF;
      fz = (pz >>> 16) & 64'hFFFF;
      i00 = int'(gx) * hts_pkg::GRID_DIM + int'(gz);
      inr = 1;
      if (fx + fz <= 65536) begin
        ia = i00; wa = 65536 - fx - fz;
        ib = i00 + hts_pkg::GRID_DIM; wb = fx;
        ic = i00 + 1; wc = fz;
      end else begin
        ia = i00 + hts_pkg::GRID_DIM; wa = 65536 - fz;
        ib = i00 + hts_pkg::GRID_DIM + 1; wb = fx + fz - 65536;
        ic = i00 + 1; wc = 65536 - fx;
      end
    endfunction

    function bit reads_unwritten(hts_pkg::in_t d);
      bit inr;
      int ia, ib, ic;
      longint wa, wb, wc;
      locate(d, inr, ia, ib, ic, wa, wb, wc);
      return inr && !(vtx_written[ia] && vtx_written[ib] && vtx_written[ic]);
    endfunction

    function void note_input(hts_pkg::in_t d);
      bit inr;
      int ia, ib, ic, idx;
      longint wa, wb, wc, acc, h, s;
      hts_pkg::out_t r;
      if (d.op == hts_pkg::OP_WRITE) begin
        idx = int'(d.vertex_col) * hts_pkg::GRID_DIM + int'(d.vertex_row);
        vtx_height[idx] = d.vertex_height;
        vtx_normal[idx] = {d.vertex_nz, d.vertex_ny, d.vertex_nx};
        vtx_written[idx] = 1;
        return;
      end
      r = '0;
      locate(d, inr, ia, ib, ic, wa, wb, wc);
      if (inr) begin
        acc = longint'($signed(vtx_height[ia])) * wa +
              longint'($signed(vtx_height[ib])) * wb +
              longint'($signed(vtx_height[ic])) * wc;
        h = ((acc + 32768) >>> 16) + longint'($signed(org_y));
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        if (h < -64'sd2147483648) h = -64'sd2147483648;
        r.height = h[31:0];
        for (int k = 0; k < 3; k++) begin
          s = longint'($signed(vtx_normal[ia][16*k +: 16])) +
              longint'($signed(vtx_normal[ib][16*k +: 16])) +
              longint'($signed(vtx_normal[ic][16*k +: 16]));
          s = (s + 120001) / 3 - 40000;
          if (k == 0) r.avg_nx = s[15:0];
          else if (k == 1) r.avg_ny = s[15:0];
          else r.avg_nz = s[15:0];
        end
        r.in_range = 1;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(hts_pkg::out_t got);
      hts_pkg::out_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.height !== exp.height) begin
        $display("%0t: height expected %h actual %h", $realtime, exp.height, got.height);
        errors++;
      end
      if (got.avg_nx !== exp.avg_nx) begin
        $display("%0t: avg_nx expected %h actual %h", $realtime, exp.avg_nx, got.avg_nx);
        errors++;
      end
      if (got.avg_ny !== exp.avg_ny) begin
        $display("%0t: avg_ny expected %h actual %h", $realtime, exp.avg_ny, got.avg_ny);
        errors++;
      end
      if (got.avg_nz !== exp.avg_nz) begin
        $display("%0t: avg_nz expected %h actual %h", $realtime, exp.avg_nz, got.avg_nz);
        errors++;
      end
      if (got.in_range !== exp.in_range) begin
        $display("%0t: in_range expected %b actual %b", $realtime, exp.in_range,
                 got.in_range);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  hts_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  hts_pkg::out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [hts_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  terrain_scoreboard sb = new();
  int  tx_idle = 0, rx_idle = 0;
  bit  hold_req = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  heightmap_terrain_sampler_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Result side: check, then choose ready for the next edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > 5000) begin
      $display("tb_heightmap_terrain_sampler_unit NOT OK");
      $finish;
    end
  end

  // Leave valid high after acceptance; the next item or a drain drops it.
  task automatic push_item(hts_pkg::in_t d);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
  endtask

  task automatic write_reg(logic [hts_pkg::CFG_IW-1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_vertex(int col, int row, logic [31:0] h, logic [15:0] nx,
                             logic [15:0] ny, logic [15:0] nz);
    hts_pkg::in_t d;
    d = hts_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    d.op = hts_pkg::OP_WRITE;
    d.vertex_col = 8'(col); d.vertex_row = 8'(row);
    d.vertex_height = h;
    d.vertex_nx = nx; d.vertex_ny = ny; d.vertex_nz = nz;
    push_item(d);
  endtask

  // Drop to the origin, which always hits written corners, if the query would not.
  task automatic send_query(logic [31:0] px, logic [31:0] pz);
    hts_pkg::in_t d;
    d = hts_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    d.op = hts_pkg::OP_QUERY;
    d.pos_x = px; d.pos_z = pz;
    if (sb.reads_unwritten(d)) begin
      d.pos_x = sb.org_x;
      d.pos_z = sb.org_z;
    end
    push_item(d);
  endtask

  function automatic logic [31:0] aim(logic [31:0] org, int span);
    longint cell_idx, target;
    cell_idx = longint'($urandom_range(span + 1)) - 1;
    target = (cell_idx <<< 32) + (longint'($urandom_range(65535)) <<< 16);
    if (sb.inv_cell != 0) target = target / longint'(sb.inv_cell);
    else target = longint'($signed($urandom));
    target = target + longint'($signed(org));
    if (target > 64'sd2147483647) target = 64'sd2147483647;
    if (target < -64'sd2147483648) target = -64'sd2147483648;
    return target[31:0];
  endfunction

  function automatic logic [31:0] rand_height();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(20000000)) - 10000000);
    endcase
  endfunction

  task automatic random_items(int count, int span);
    int c;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 35) begin
        c = ($urandom_range(9) == 0) ? 255 : span + 1;
        send_vertex($urandom_range(c), $urandom_range(c), rand_height(),
                    16'($urandom), 16'($urandom), 16'($urandom));
      end else if ($urandom_range(99) < 20) begin
        send_query($urandom, $urandom);
      end else begin
        send_query(aim(sb.org_x, span), aim(sb.org_z, span));
      end
    end
  endtask

  logic [31:0] ph_ox [6] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000,
                             32'hFFF0_0000, 32'h0};
  logic [31:0] ph_oy [6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                             32'hFFFF_0000, 32'h0};
  logic [31:0] ph_oz [6] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFE_0000,
                             32'h0010_0000, 32'h0};
  logic [31:0] ph_inv [6] = '{32'h0001_0000, 32'h00FF_FFFF, 32'h0, 32'h0000_4000,
                              32'h0003_5555, 32'hFFFF_FFFF};
  logic [31:0] ph_gp [6] = '{32'd6, 32'd2, 32'd0, 32'd256, 32'd9, 32'h1FF};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Corners of cell (0,0) plus (255,255), mostly at the extremes of height and normal.
    send_vertex(0, 0, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_vertex(1, 0, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_vertex(0, 1, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'h0001);
    send_vertex(1, 1, 32'h0001_0000, 16'h0000, 16'hFFFF, 16'h4000);
    send_vertex(255, 255, 32'h0, 16'h0, 16'h0, 16'h0);
    send_query(32'h0, 32'h0);
    send_query(32'h0000_8000, 32'h0000_8000);   // on the diagonal: lower triangle
    send_query(32'h0000_C000, 32'h0000_C000);   // upper triangle, uses (1,1)
    send_query(32'h0000_FFFF, 32'h0000_0001);
    send_query(32'hFFFF_FFFF, 32'h0000_4000);   // just below the grid
    send_query(32'h00FF_0000, 32'h0);           // last column, off the grid
    send_query(32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    write_reg(hts_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);     // saturate upwards
    send_query(32'h0, 32'h0);
    send_query(32'h0000_4000, 32'h0);
    drain();
    write_reg(hts_pkg::CFG_ORIGIN_Y, 32'h8000_0000);
    send_query(32'h0000_0000, 32'h0000_F000);
    send_query(32'h0000_2000, 32'h0000_E000);
    drain();
    write_reg(3'd7, 32'hFFFF_FFFF);             // no such register

    for (int p = 0; p < 6; p++) begin
      drain();
      tx_idle = (p < 2) ? 23 : ((p < 4) ? 48 : 0);
      rx_idle = (p < 2) ? 48 : ((p < 4) ? 23 : 0);
      write_reg(hts_pkg::CFG_ORIGIN_X, ph_ox[p]);
      write_reg(hts_pkg::CFG_ORIGIN_Y, ph_oy[p]);
      write_reg(hts_pkg::CFG_ORIGIN_Z, ph_oz[p]);
      write_reg(hts_pkg::CFG_INV_CELL, ph_inv[p]);
      write_reg(hts_pkg::CFG_GRID_PTS, ph_gp[p]);
      // Fill the corner cells so off-target queries always have somewhere to land.
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++)
          send_vertex(c, r, rand_height(), 16'($urandom), 16'($urandom),
                      16'($urandom));
      random_items(80, 7);
      if (p == 1) begin
        hold_req = 1;
        random_items(40, 7);
        drain();
      end
      if (p == 4) begin
        in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
      end
      random_items(p == 1 ? 45 : 85, 7);
    end
    drain();

    if (sb.errors == 0)
      $display("tb_heightmap_terrain_sampler_unit OK");
    else
      $display("tb_heightmap_terrain_sampler_unit NOT OK");
    $finish;
  end
endmodule
